// ----- rtl/hte_pkg.sv -----
// shared constants and types for the huffman table encoder
`timescale 1ns / 1ps
package hte_pkg;

	// code table geometry
	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int TBL_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	// packer geometry: up to seven held bits plus one whole code
	localparam int ACC_W   = LEN_LIMIT + 8;
	localparam int CNT_W   = $clog2(ACC_W + 1);
	localparam int TOTAL_W = 48;

	// work queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// item modes
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_ENCODE = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	// one unit of work for the packer
	typedef struct packed {
		logic              flush;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} work_t;

	// one result beat
	typedef struct packed {
		logic [7:0]         data_byte;
		logic [3:0]         bits_in_byte;
		logic               run_last;
		logic [TOTAL_W-1:0] stream_bits;
	} out_t;

endpackage

// ----- rtl/hte_front.sv -----
// front end: table loads, table lookup and work classification
`timescale 1ns / 1ps
module hte_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                mode,
	input  logic [7:0]                symbol,
	input  logic [hte_pkg::CODE_W-1:0] code_bits,
	input  logic [hte_pkg::LEN_W-1:0] code_len,
	output logic                      q_wr,
	output hte_pkg::work_t            q_item,
	input  logic                      q_full
);
	import hte_pkg::*;

	logic [LEN_W+CODE_W-1:0] table_mem [SYMBOL_COUNT];
	logic [LEN_W+CODE_W-1:0] rd_s1;
	logic                    v_s1;
	logic                    flush_s1;
	logic                    sym_ok_s1;

	logic                    accept;
	logic                    sym_ok;
	logic [TBL_AW-1:0]       idx;
	logic [LEN_W-1:0]        load_len;
	logic [CODE_W-1:0]       load_code;
	logic [LEN_W-1:0]        ent_len;
	logic                    need_push;
	logic                    go_s1;

	// index range and table address
	assign sym_ok = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
	assign idx    = symbol[TBL_AW-1:0];
	assign accept = push && !full;

	// saturate the length and clear code bits above it
	always_comb begin
		load_len = (code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_len;
		load_code = code_bits & ~({CODE_W{1'b1}} << load_len);
	end

	// table write on load, registered read on every accepted beat
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD && sym_ok) begin
			table_mem[idx] <= {load_len, load_code};
		end
		if (accept) begin
			rd_s1 <= table_mem[idx];
		end
	end

	// classify the looked-up entry
	always_comb begin
		ent_len = rd_s1[LEN_W+CODE_W-1:CODE_W];
		if (ent_len > LEN_W'(LEN_LIMIT)) begin
			ent_len = LEN_W'(LEN_LIMIT);
		end
		need_push = v_s1 && (flush_s1 || (sym_ok_s1 && ent_len != '0));
		q_wr = need_push && !q_full;
		q_item.flush = flush_s1;
		q_item.len = ent_len;
		q_item.code = rd_s1[CODE_W-1:0];
		go_s1 = !(need_push && q_full);
		full = v_s1 && !go_s1;
	end

	// lookup stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= (mode == MODE_ENCODE) || (mode == MODE_FLUSH);
		end else if (go_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= (mode == MODE_FLUSH);
			sym_ok_s1 <= sym_ok;
		end
	end

endmodule

// ----- rtl/hte_queue.sv -----
// short work queue between front and back
`timescale 1ns / 1ps
module hte_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  hte_pkg::work_t wr_item,
	output logic           full,
	input  logic           rd,
	output hte_pkg::work_t rd_item,
	output logic           empty
);
	import hte_pkg::*;

	work_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = slot_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
		end
	end

`ifndef SYNTH
	// fill count never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("work queue count out of range");

	// front never offers work into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("work queue overrun");
`endif

endmodule

// ----- rtl/hte_back.sv -----
// back end: bit packer, bit counter and result buffer
`timescale 1ns / 1ps
module hte_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hte_pkg::work_t head,
	input  logic           q_empty,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output hte_pkg::out_t  beat
);
	import hte_pkg::*;

	logic [ACC_W-1:0]   v_q;
	logic [CNT_W-1:0]   n_q;
	logic [TOTAL_W-1:0] total_q;
	out_t               ob_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         ocnt_q;

	logic               pop_ok;
	logic               room;
	logic               have_byte;
	logic               take;
	logic               emit_byte;
	logic               emit_part;
	logic [CNT_W-1:0]   n_rest;
	logic [ACC_W-1:0]   byte_sh;
	logic [TOTAL_W:0]   sum;
	out_t               new_beat;

	assign pop_ok    = pop && !empty;
	assign room      = (ocnt_q != 2'd2) || pop_ok;
	assign have_byte = (n_q >= CNT_W'(8));
	assign take      = !q_empty && !have_byte && (!head.flush || n_q == '0 || room);
	assign emit_byte = have_byte && room;
	assign emit_part = take && head.flush && (n_q != '0);
	assign q_rd      = take;

	// byte extraction and next beat
	always_comb begin
		n_rest = n_q - CNT_W'(8);
		byte_sh = v_q >> n_rest;
		sum = {1'b0, total_q} + (TOTAL_W+1)'(head.len);
		new_beat.stream_bits = total_q;
		if (have_byte) begin
			new_beat.data_byte = byte_sh[7:0];
			new_beat.bits_in_byte = 4'd8;
			new_beat.run_last = (n_rest < CNT_W'(8));
		end else begin
			new_beat.data_byte = v_q[7:0] & ~(8'hFF << n_q[2:0]);
			new_beat.bits_in_byte = {1'b0, n_q[2:0]};
			new_beat.run_last = 1'b1;
		end
	end

	// packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			n_q <= '0;
			total_q <= '0;
		end else if (emit_byte) begin
			n_q <= n_rest;
		end else if (take) begin
			if (head.flush) begin
				v_q <= '0;
				n_q <= '0;
				total_q <= '0;
			end else begin
				v_q <= (v_q << head.len) | ACC_W'(head.code);
				n_q <= n_q + CNT_W'(head.len);
				total_q <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
			end
		end
	end

	// result buffer storage
	always_ff @(posedge clk) begin
		if (emit_byte || emit_part) begin
			ob_q[wp_q] <= new_beat;
		end
	end

	// result buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (emit_byte || emit_part) begin
				wp_q <= !wp_q;
			end
			if (pop_ok) begin
				rp_q <= !rp_q;
			end
			ocnt_q <= ocnt_q + 2'(emit_byte || emit_part) - 2'(pop_ok);
		end
	end

	assign empty = (ocnt_q == '0);
	assign beat  = ob_q[rp_q];

`ifndef SYNTH
	// held bits always fit the accumulator
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q < CNT_W'(ACC_W))
		else $error("packer bit count out of range");

	// a taken flush leaves the packer and counter cleared
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.flush) |=> (n_q == '0 && total_q == '0))
		else $error("flush did not clear packer");

	// result buffer never holds more than two beats
	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result buffer overflow");
`endif

endmodule

// ----- rtl/huffman_table_encoder.sv -----
// top level of the huffman table encoder
// Static-table Huffman encoder with byte packer. Mode 0 writes one code table
// entry, mode 1 appends the code of one byte to the packer, mode 2 emits any
// partial byte right-aligned and clears the packer and the bit count. The front
// end takes one input beat per clock while its lookup stage can pass work into
// a four-deep work queue; loads and items that produce nothing finish there.
// The back end packer absorbs one code at a time and emits every full byte it
// holds before it takes the next item; bytes and the partial byte of a flush
// wait for room in the result buffer. Results leave through a two-beat buffer,
// so the packer keeps working while a result waits.
// Encoding a symbol whose table entry was never loaded gives undefined output.
`timescale 1ns / 1ps
module huffman_table_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [7:0]                    symbol,
	input  logic [hte_pkg::CODE_W-1:0]    code_bits,
	input  logic [hte_pkg::LEN_W-1:0]     code_len,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    data_byte,
	output logic [3:0]                    bits_in_byte,
	output logic                          run_last,
	output logic [hte_pkg::TOTAL_W-1:0]   stream_bits
);
	import hte_pkg::*;

	logic  q_wr;
	logic  q_full;
	logic  q_rd;
	logic  q_empty;
	work_t q_wr_item;
	work_t q_head;
	out_t  beat;

	// front end
	hte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.symbol    (symbol),
		.code_bits (code_bits),
		.code_len  (code_len),
		.q_wr      (q_wr),
		.q_item    (q_wr_item),
		.q_full    (q_full)
	);

	// work queue
	hte_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd      (q_rd),
		.rd_item (q_head),
		.empty   (q_empty)
	);

	// back end
	hte_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.beat    (beat)
	);

	// result ports
	assign data_byte    = beat.data_byte;
	assign bits_in_byte = beat.bits_in_byte;
	assign run_last     = beat.run_last;
	assign stream_bits  = beat.stream_bits;

endmodule

// ----- test/tb.sv -----
// testbench for the huffman table encoder: table loads, byte packing and flushes
`timescale 1ns / 1ps
module tb;
	import hte_pkg::*;

	// unused mode value, the block drops it
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;
	localparam int RANDOM_ITEMS = 130;

	typedef struct {
		logic [1:0]        mode;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} stim_t;

	logic                clk;
	logic                arst_n;
	logic                push = 1'b0;
	logic                full;
	logic [1:0]          mode = MODE_LOAD;
	logic [7:0]          symbol = '0;
	logic [CODE_W-1:0]   code_bits = '0;
	logic [LEN_W-1:0]    code_len = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [7:0]          data_byte;
	logic [3:0]          bits_in_byte;
	logic                run_last;
	logic [TOTAL_W-1:0]  stream_bits;

	stim_t  stim_items[$];
	out_t   pending_bytes[$];
	int     err_count = 0;

	// generator side bookkeeping: only loaded symbols get encoded
	bit          gen_loaded[SYMBOL_COUNT];
	logic [7:0]  loaded_syms[$];

	// packer state of the predictor
	logic [LEN_W-1:0]   tbl_len[SYMBOL_COUNT];
	logic [CODE_W-1:0]  tbl_code[SYMBOL_COUNT];
	logic [7:0]         acc_byte = '0;
	int                 acc_cnt = 0;
	logic [TOTAL_W-1:0] bit_count = '0;

	huffman_table_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.symbol       (symbol),
		.code_bits    (code_bits),
		.code_len     (code_len),
		.empty        (empty),
		.pop          (pop),
		.data_byte    (data_byte),
		.bits_in_byte (bits_in_byte),
		.run_last     (run_last),
		.stream_bits  (stream_bits)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// append one expected result beat
	task automatic queue_beat(input out_t b);
		pending_bytes.insert(pending_bytes.size(), b);
	endtask

	// work out the bytes one accepted item produces
	task automatic pack_item(input stim_t it);
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
		out_t              res;
		int                n_total;
		int                n_out;
		int                i;
		n_out = 0;
		case (it.mode)
			MODE_LOAD: begin
				if (int'(it.symbol) < SYMBOL_COUNT) begin
					len = (it.code_len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : it.code_len;
					code = (len >= 32) ? it.code_bits
						: it.code_bits & ((32'd1 << len) - 32'd1);
					tbl_len[it.symbol] = len;
					tbl_code[it.symbol] = code;
				end
			end
			MODE_ENCODE: begin
				len = '0;
				code = '0;
				if (int'(it.symbol) < SYMBOL_COUNT) begin
					len = tbl_len[it.symbol];
					code = tbl_code[it.symbol];
				end
				if (len > 32)
					len = 6'd32;
				if (len != 0) begin
					if (bit_count > COUNT_MAX - TOTAL_W'(len))
						bit_count = COUNT_MAX;
					else
						bit_count = bit_count + TOTAL_W'(len);
					n_total = (acc_cnt + int'(len)) / 8;
					for (i = int'(len); i > 0; i--) begin
						acc_byte = {acc_byte[6:0], code[i-1]};
						acc_cnt++;
						if (acc_cnt == 8) begin
							n_out++;
							res.data_byte = acc_byte;
							res.bits_in_byte = 4'd8;
							res.run_last = (n_out == n_total);
							res.stream_bits = bit_count;
							queue_beat(res);
							acc_byte = '0;
							acc_cnt = 0;
						end
					end
				end
			end
			MODE_FLUSH: begin
				if (acc_cnt > 0) begin
					res.data_byte = acc_byte;
					res.bits_in_byte = 4'(acc_cnt);
					res.run_last = 1'b1;
					res.stream_bits = bit_count;
					queue_beat(res);
				end
				acc_byte = '0;
				acc_cnt = 0;
				bit_count = '0;
			end
			default: begin
			end
		endcase
	endtask

	// queue one item for the driver
	task automatic add_item(input logic [1:0] m, input logic [7:0] s,
			input logic [CODE_W-1:0] b, input logic [LEN_W-1:0] l);
		stim_t it;
		it.mode = m;
		it.symbol = s;
		it.code_bits = b;
		it.code_len = l;
		stim_items.insert(stim_items.size(), it);
		if (m == MODE_LOAD && int'(s) < SYMBOL_COUNT && !gen_loaded[s]) begin
			gen_loaded[s] = 1'b1;
			loaded_syms.insert(loaded_syms.size(), s);
		end
	endtask

	// driver: bursts of beats with random gaps, holds a beat while full
	int burst_left = 8;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				pack_item(stim_items.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (!(push && full)) begin
				if (gap_left > 0 || stim_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					push <= 1'b0;
				end else begin
					push      <= 1'b1;
					mode      <= stim_items[0].mode;
					symbol    <= stim_items[0].symbol;
					code_bits <= stim_items[0].code_bits;
					code_len  <= stim_items[0].code_len;
				end
			end
		end
	end

	// monitor: check each result beat, pop on a rotating stall pattern
	logic [15:0] pop_pat = 16'hFFFF;
	int          pat_age = 0;
	always @(posedge clk) begin
		out_t exp_beat;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_bytes.size() == 0) begin
					$error("result beat with nothing expected: data_byte %0h", data_byte);
					err_count++;
				end else begin
					exp_beat = pending_bytes.pop_front();
					if (data_byte !== exp_beat.data_byte) begin
						$error("data_byte: expected %0h, got %0h", exp_beat.data_byte, data_byte);
						err_count++;
					end
					if (bits_in_byte !== exp_beat.bits_in_byte) begin
						$error("bits_in_byte: expected %0d, got %0d",
							exp_beat.bits_in_byte, bits_in_byte);
						err_count++;
					end
					if (run_last !== exp_beat.run_last) begin
						$error("run_last: expected %0b, got %0b", exp_beat.run_last, run_last);
						err_count++;
					end
					if (stream_bits !== exp_beat.stream_bits) begin
						$error("stream_bits: expected %0d, got %0d",
							exp_beat.stream_bits, stream_bits);
						err_count++;
					end
				end
			end
			// new stall pattern every so often
			if (pat_age == 99) begin
				pat_age = 0;
				case ($urandom_range(0, 3))
					0: pop_pat <= 16'hFFFF;
					1: pop_pat <= 16'($urandom) | 16'h0001;
					2: pop_pat <= 16'h0101;
					default: pop_pat <= 16'hF0F0;
				endcase
			end else begin
				pat_age++;
				pop_pat <= {pop_pat[0], pop_pat[15:1]};
			end
			pop <= pop_pat[0];
		end
	end

	// stimulus, reset and end of run
	initial begin
		int count;
		int r;
		logic [LEN_W-1:0] l;
		arst_n = 1'b0;

		// directed: table extremes, zero-length codes, saturation, flushes
		add_item(MODE_FLUSH, 8'd0, '0, '0);
		add_item(MODE_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
		add_item(MODE_ENCODE, 8'd0, '0, '0);
		add_item(MODE_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
		add_item(MODE_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd1);
		add_item(MODE_LOAD, 8'd2, 32'h1234_5678, 6'd63);
		add_item(MODE_LOAD, 8'd3, 32'hFFFF_FFFA, 6'd3);
		add_item(MODE_LOAD, 8'h80, 32'hCAFE_00A5, 6'd8);
		add_item(MODE_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);
		add_item(MODE_ENCODE, 8'd1, '0, '0);
		add_item(MODE_ENCODE, 8'd2, '0, '0);
		add_item(MODE_ENCODE, 8'd3, '0, '0);
		add_item(MODE_SPARE, 8'd1, 32'hFFFF_FFFF, 6'd63);
		add_item(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		add_item(MODE_FLUSH, 8'd0, '0, '0);
		for (int k = 0; k < 7; k++)
			add_item(MODE_ENCODE, 8'd1, '0, '0);
		add_item(MODE_ENCODE, 8'd2, '0, '0);
		add_item(MODE_ENCODE, 8'h80, '0, '0);
		add_item(MODE_FLUSH, 8'd0, '0, '0);

		// random: mostly loads and encodes of loaded symbols, some flushes and noise
		count = 0;
		while (count < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 14) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: l = LEN_W'($urandom_range(1, 10));
					6, 7: l = LEN_W'($urandom_range(11, 32));
					8: l = '0;
					default: l = LEN_W'($urandom_range(33, 63));
				endcase
				add_item(MODE_LOAD, 8'($urandom), $urandom, l);
				count++;
			end else if (r < 84) begin
				add_item(MODE_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
					$urandom, LEN_W'($urandom));
				count++;
			end else if (r < 94) begin
				add_item(MODE_FLUSH, 8'($urandom), $urandom, LEN_W'($urandom));
				count++;
			end else begin
				add_item(MODE_SPARE, 8'($urandom), $urandom, LEN_W'($urandom));
			end
		end
		add_item(MODE_FLUSH, 8'd0, '0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the queues to drain, then a few quiet cycles
		do
			@(posedge clk);
		while (stim_items.size() != 0 || push || pending_bytes.size() != 0);
		repeat (40) @(posedge clk);

		if (err_count == 0 && pending_bytes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
